// ===== rtl/assert_macros.svh =====
// assertion macros used by the top level rtl file
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define PFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset too
`define PFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pfd_pkg.sv =====
// types, constants and word layouts for the ppm pulse frame decoder
// no dependencies; imported by every rtl module of the block
package pfd_pkg;

  localparam int CHANNELS    = 8;
  localparam int MAX_WRAPS   = 63;
  localparam int COUNT_W     = 16;
  localparam int WIDTH_W     = 22;
  localparam int SLOT_W      = 4;
  localparam int CHAN_W      = 3;
  localparam int WRAP_W      = $clog2(MAX_WRAPS + 1);
  localparam int STORE_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  // wraps * (top + 1) + count, with headroom
  localparam int TOTAL_W     = WRAP_W + COUNT_W + 2;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX      = '1;
  localparam logic [COUNT_W-1:0] TOP_RESET      = 16'hFFFF;
  localparam logic [WIDTH_W-1:0] SYNC_THR_RESET = 22'd3500;

  typedef logic [0:0] cfg_addr_t;
  localparam cfg_addr_t CFG_COUNTER_TOP    = 1'b0;
  localparam cfg_addr_t CFG_SYNC_THRESHOLD = 1'b1;

  typedef enum logic [1:0] {
    EVT_SYNC    = 2'd0,
    EVT_CHANNEL = 2'd1,
    EVT_TIMEOUT = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic               overflow_event;
    logic               capture_event;
    logic [COUNT_W-1:0] capture_count;
  } in_word_t;

  typedef struct packed {
    event_kind_t        event_kind;
    logic [CHAN_W-1:0]  channel_number;
    logic [WIDTH_W-1:0] pulse_width;
    logic               frame_done;
  } out_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] counter_top;
    logic [WIDTH_W-1:0] sync_threshold;
  } cfg_t;

endpackage

// ===== rtl/ppm_pulse_frame_decoder.sv =====
// top level of the ppm pulse frame decoder: input and result registers
// depends on pfd_pkg, pfd_cfg_regs, pfd_frame_ctrl and assert_macros.svh
//
// Decodes a ppm pulse train from timer events, one event word per clock.
// Each input word carries an overflow flag, a capture flag and the count
// latched at the edge. Rising edges record the start count; falling edges
// yield the high time, wraps * (counter_top + 1) + end - start, saturated
// to 22 bits. A width at or above sync_threshold opens a frame (kind 0);
// inside a frame each shorter pulse fills the next of eight slots (kind 1,
// frame_done on the last). A pulse held high through more than 63 counter
// wraps is dropped and reported as a timeout (kind 2), and edge tracking
// goes back to waiting for a rising edge. At most one result word per event.
// Rate: one event word per cycle while out_ready takes each result. A word
// is held in the input register, then the width multiply-add, threshold
// compare and slot update run combinationally into the result register,
// which drives out_valid. The only loop is the per-event state update
// (edge, wrap count, slot), which is registered as each word moves on.
// Back pressure on out_ready stalls the input only while a result is held.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once
// and are meant to be made while the block is idle; no clearing pass.
module ppm_pulse_frame_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pfd_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pfd_pkg::out_word_t          out_data,
  input  logic                        cfg_we,
  input  pfd_pkg::cfg_addr_t          cfg_addr,
  input  logic [pfd_pkg::WIDTH_W-1:0] cfg_wdata
);
  import pfd_pkg::*;

  `include "assert_macros.svh"

  cfg_t      cfg;

  // input register
  logic      in_valid_r, in_valid_nxt;
  in_word_t  in_data_r;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_data_r;

  logic      advance;
  logic      res_valid;
  out_word_t res_word;

  // terms for the checks below
  logic      out_stall;
  logic      out_timeout;
  logic      timeout_empty;
  logic      out_done;
  logic      out_is_chan;

  pfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pfd_frame_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .in_word   (in_data_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // a held word moves on once the result register has room
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_ready ? in_valid : in_valid_r;

    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && res_valid) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (advance && res_valid) begin
      out_data_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_stall     = out_valid_r && !out_ready;
  assign out_timeout   = out_valid_r && (out_data_r.event_kind == EVT_TIMEOUT);
  assign timeout_empty = (out_data_r.pulse_width == '0) &&
                         (out_data_r.channel_number == '0) && !out_data_r.frame_done;
  assign out_done      = out_valid_r && out_data_r.frame_done;
  assign out_is_chan   = (out_data_r.event_kind == EVT_CHANNEL);

  // a stalled result word is never overwritten
  `PFD_ASSERT(a_out_hold, out_stall |=> out_valid_r && $stable(out_data_r), "stalled word changed")
  // timeout words carry no width, slot or frame end
  `PFD_ASSERT(a_timeout_clean, out_timeout |-> timeout_empty, "timeout word has payload")
  // frame end only flags a channel word
  `PFD_ASSERT(a_done_kind, out_done |-> out_is_chan, "frame_done on non-channel word")
  // nothing is shown straight after reset
  `PFD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid_r && !in_valid_r, "valid after reset")

endmodule

// ===== rtl/pfd_cfg_regs.sv =====
// configuration registers: counter top and sync threshold
// depends on pfd_pkg
module pfd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  pfd_pkg::cfg_addr_t         cfg_addr,
  input  logic [pfd_pkg::WIDTH_W-1:0] cfg_wdata,
  output pfd_pkg::cfg_t              cfg
);
  import pfd_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_COUNTER_TOP:    cfg_nxt.counter_top    = cfg_wdata[COUNT_W-1:0];
        CFG_SYNC_THRESHOLD: cfg_nxt.sync_threshold = cfg_wdata;
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.counter_top    <= TOP_RESET;
      cfg_r.sync_threshold <= SYNC_THR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/pfd_width_calc.sv =====
// pulse width: wraps * (top + 1) + end - start, saturated to 22 bits
// depends on pfd_pkg
module pfd_width_calc (
  input  logic [pfd_pkg::WRAP_W-1:0]  wraps,
  input  logic [pfd_pkg::COUNT_W-1:0] counter_top,
  input  logic [pfd_pkg::COUNT_W-1:0] end_count,
  input  logic [pfd_pkg::COUNT_W-1:0] start_count,
  output logic [pfd_pkg::WIDTH_W-1:0] width
);
  import pfd_pkg::*;

  logic [COUNT_W:0]   period;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] diff;

  always_comb begin
    period = {1'b0, counter_top} + {{COUNT_W{1'b0}}, 1'b1};
    total  = TOTAL_W'(wraps) * TOTAL_W'(period) + TOTAL_W'(end_count);
    diff   = total - TOTAL_W'(start_count);
    // a total below the start count saturates, as does an oversize width
    if (total < TOTAL_W'(start_count)) begin
      width = WIDTH_MAX;
    end else if (diff > TOTAL_W'(WIDTH_MAX)) begin
      width = WIDTH_MAX;
    end else begin
      width = diff[WIDTH_W-1:0];
    end
  end

endmodule

// ===== rtl/pfd_frame_ctrl.sv =====
// edge tracking, overflow counting, frame and slot control, channel store
// depends on pfd_pkg and pfd_width_calc
module pfd_frame_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  pfd_pkg::in_word_t  in_word,
  input  pfd_pkg::cfg_t      cfg,
  output logic               res_valid,
  output pfd_pkg::out_word_t res_word
);
  import pfd_pkg::*;

  logic                high_seen_r, high_seen_nxt;
  logic [WRAP_W-1:0]   wrap_count_r, wrap_count_nxt;
  logic [COUNT_W-1:0]  rise_count_r, rise_count_nxt;
  logic                frame_active_r, frame_active_nxt;
  logic [SLOT_W-1:0]   next_slot_r, next_slot_nxt;
  logic [COUNT_W-1:0]  channel_store_r [CHANNELS];

  logic                timeout;
  logic                high_eff;
  logic [WRAP_W-1:0]   wrap_eff;
  logic [WIDTH_W-1:0]  width;
  logic [SLOT_W:0]     slot_inc;
  logic                slot_ok;
  logic                store_we;

  pfd_width_calc u_width (
    .wraps       (wrap_eff),
    .counter_top (cfg.counter_top),
    .end_count   (in_word.capture_count),
    .start_count (rise_count_r),
    .width       (width)
  );

  always_comb begin
    // overflow first
    timeout  = in_word.overflow_event && high_seen_r &&
               (WRAP_W'(MAX_WRAPS) <= wrap_count_r);
    high_eff = high_seen_r && !timeout;
    wrap_eff = timeout ? '0 :
               (in_word.overflow_event && high_seen_r) ? wrap_count_r + 1'b1 :
               wrap_count_r;

    slot_inc = {1'b0, next_slot_r} + {{SLOT_W{1'b0}}, 1'b1};
    slot_ok  = (32'(next_slot_r) < CHANNELS);

    high_seen_nxt    = high_eff;
    wrap_count_nxt   = wrap_eff;
    rise_count_nxt   = timeout ? '0 : rise_count_r;
    frame_active_nxt = frame_active_r;
    next_slot_nxt    = next_slot_r;
    store_we         = 1'b0;

    res_valid               = timeout;
    res_word.event_kind     = EVT_TIMEOUT;
    res_word.channel_number = '0;
    res_word.pulse_width    = '0;
    res_word.frame_done     = 1'b0;

    if (in_word.capture_event) begin
      if (high_eff) begin
        if (width >= cfg.sync_threshold) begin
          frame_active_nxt     = 1'b1;
          next_slot_nxt        = '0;
          res_valid            = 1'b1;
          res_word.event_kind  = EVT_SYNC;
          res_word.pulse_width = width;
        end else if (frame_active_r) begin
          store_we                = slot_ok;
          next_slot_nxt           = slot_inc[SLOT_W-1:0];
          res_valid               = 1'b1;
          res_word.event_kind     = EVT_CHANNEL;
          res_word.channel_number = next_slot_r[CHAN_W-1:0];
          res_word.pulse_width    = width;
          res_word.frame_done     = (32'(slot_inc) >= CHANNELS);
          if (32'(slot_inc) >= CHANNELS) begin
            frame_active_nxt = 1'b0;
          end
        end
        high_seen_nxt  = 1'b0;
        wrap_count_nxt = '0;
      end else begin
        // rising edge
        high_seen_nxt  = 1'b1;
        wrap_count_nxt = '0;
        rise_count_nxt = in_word.capture_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_seen_r    <= 1'b0;
      wrap_count_r   <= '0;
      rise_count_r   <= '0;
      frame_active_r <= 1'b0;
      next_slot_r    <= '0;
    end else if (step) begin
      high_seen_r    <= high_seen_nxt;
      wrap_count_r   <= wrap_count_nxt;
      rise_count_r   <= rise_count_nxt;
      frame_active_r <= frame_active_nxt;
      next_slot_r    <= next_slot_nxt;
    end
  end

  // slot store keeps the low 16 bits of each channel width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        channel_store_r[i] <= '0;
      end
    end else if (step && store_we) begin
      channel_store_r[next_slot_r[STORE_IDX_W-1:0]] <= width[COUNT_W-1:0];
    end
  end

endmodule
